@@ sv/ray_paraboloid_intersect_core_macros.svh @@
// Assertion helpers shared by the intersector modules.
`ifndef RAY_PARABOLOID_INTERSECT_CORE_MACROS_SVH
`define RAY_PARABOLOID_INTERSECT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rpi_pkg.sv @@
package rpi_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_VERTEX_X = 3'd0,
    REG_VERTEX_Y = 3'd1,
    REG_VERTEX_Z = 3'd2,
    REG_AXIS_X   = 3'd3,
    REG_AXIS_Y   = 3'd4,
    REG_AXIS_Z   = 3'd5,
    REG_FOCAL_K  = 3'd6
  } cfg_reg_t;

  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = 2;
  localparam int MID_CNT_W = 3;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               degenerate;
    logic signed [31:0] root_near;
    logic signed [31:0] root_far;
  } out_item_t;

  // Coefficients handed from the front to the back
  typedef struct packed {
    logic               hit;
    logic               degen;
    logic signed [31:0] h;
    logic signed [31:0] a;
    logic        [63:0] q;
  } mid_item_t;

  // Clamp a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [31:0] r;
    if (v > 70'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -70'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/rpi_queue.sv @@
`include "ray_paraboloid_intersect_core_macros.svh"

module rpi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rpi_pkg::mid_item_t wr_item,
  output logic              full,
  input  logic              pop,
  output rpi_pkg::mid_item_t rd_item,
  output logic              empty
);
  import rpi_pkg::*;

  mid_item_t            mem_r [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [MID_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [MID_CNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item = mem_r[rd_ptr_r];
  assign full    = (cnt_r == MID_CNT_W'(MID_DEPTH));
  assign empty   = (cnt_r == '0);

  `RPI_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MID_CNT_W'(MID_DEPTH), "queue overfilled")
  `RPI_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
  `RPI_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count missed push")

endmodule

@@ sv/rpi_front.sv @@
module rpi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_push,
  input  rpi_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               mid_push,
  output rpi_pkg::mid_item_t mid_item,
  input  logic               mid_full
);
  import rpi_pkg::*;

  localparam logic [17:0] AXIS_ONE = 18'(64'd1 << FRAC_BITS);
  localparam logic [31:0] K_ONE    = 32'(64'd1 << FRAC_BITS);

  // Configuration registers
  logic signed [31:0] vx_r, vy_r, vz_r, k_r;
  logic signed [17:0] ax_r, ay_r, az_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= '0;
      vy_r <= '0;
      vz_r <= '0;
      ax_r <= '0;
      ay_r <= AXIS_ONE;
      az_r <= '0;
      k_r  <= K_ONE;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_VERTEX_X: vx_r <= cfg_data;
        REG_VERTEX_Y: vy_r <= cfg_data;
        REG_VERTEX_Z: vz_r <= cfg_data;
        REG_AXIS_X:   ax_r <= cfg_data[17:0];
        REG_AXIS_Y:   ay_r <= cfg_data[17:0];
        REG_AXIS_Z:   az_r <= cfg_data[17:0];
        REG_FOCAL_K:  k_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: advance unless the last stage is blocked
  logic [8:1] vld_r;
  logic       f_en;

  assign f_en     = !vld_r[8] || !mid_full;
  assign in_full  = !f_en;
  assign mid_push = vld_r[8] && !mid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (f_en) begin
      vld_r <= {vld_r[7:1], in_push};
    end
  end

  // Stage 1: offset from vertex
  logic signed [32:0] x1_r [3];
  logic signed [31:0] d1_r [3];

  always_ff @(posedge clk) begin
    if (f_en) begin
      x1_r[0] <= 33'(in_item.origin_x) - 33'(vx_r);
      x1_r[1] <= 33'(in_item.origin_y) - 33'(vy_r);
      x1_r[2] <= 33'(in_item.origin_z) - 33'(vz_r);
      d1_r[0] <= in_item.dir_x;
      d1_r[1] <= in_item.dir_y;
      d1_r[2] <= in_item.dir_z;
    end
  end

  // Stage 2: element products, floored to the fixed-point grid
  logic signed [65:0] pdd_r [3];
  logic signed [65:0] pdx_r [3];
  logic signed [65:0] pxx_r [3];
  logic signed [65:0] pda_r [3];
  logic signed [65:0] pxa_r [3];
  logic signed [17:0] ax_v [3];

  assign ax_v[0] = ax_r;
  assign ax_v[1] = ay_r;
  assign ax_v[2] = az_r;

  always_ff @(posedge clk) begin
    if (f_en) begin
      for (int i = 0; i < 3; i++) begin
        pdd_r[i] <= (66'(d1_r[i]) * 66'(d1_r[i])) >>> FRAC_BITS;
        pdx_r[i] <= (66'(d1_r[i]) * 66'(x1_r[i])) >>> FRAC_BITS;
        pxx_r[i] <= (66'(x1_r[i]) * 66'(x1_r[i])) >>> FRAC_BITS;
        pda_r[i] <= (66'(d1_r[i]) * 66'(ax_v[i])) >>> FRAC_BITS;
        pxa_r[i] <= (66'(x1_r[i]) * 66'(ax_v[i])) >>> FRAC_BITS;
      end
    end
  end

  // Stage 3: dot products
  logic signed [31:0] uu3_r, ux3_r, xx3_r, ua3_r, xa3_r;

  always_ff @(posedge clk) begin
    if (f_en) begin
      uu3_r <= sat32(70'(pdd_r[0]) + 70'(pdd_r[1]) + 70'(pdd_r[2]));
      ux3_r <= sat32(70'(pdx_r[0]) + 70'(pdx_r[1]) + 70'(pdx_r[2]));
      xx3_r <= sat32(70'(pxx_r[0]) + 70'(pxx_r[1]) + 70'(pxx_r[2]));
      ua3_r <= sat32(70'(pda_r[0]) + 70'(pda_r[1]) + 70'(pda_r[2]));
      xa3_r <= sat32(70'(pxa_r[0]) + 70'(pxa_r[1]) + 70'(pxa_r[2]));
    end
  end

  // Stage 4: axial terms with focal offset
  logic signed [31:0] uu4_r, ux4_r, xx4_r, ua4_r, xa4_r, t2_r, t4_r;

  always_ff @(posedge clk) begin
    if (f_en) begin
      uu4_r <= uu3_r;
      ux4_r <= ux3_r;
      xx4_r <= xx3_r;
      ua4_r <= ua3_r;
      xa4_r <= xa3_r;
      t2_r  <= sat32(70'(xa3_r) + (70'(k_r) <<< 1));
      t4_r  <= sat32(70'(xa3_r) + (70'(k_r) <<< 2));
    end
  end

  // Stage 5: axial products
  logic signed [31:0] uu5_r, ux5_r, xx5_r;
  logic signed [63:0] m1_r, m2_r, m3_r;

  always_ff @(posedge clk) begin
    if (f_en) begin
      uu5_r <= uu4_r;
      ux5_r <= ux4_r;
      xx5_r <= xx4_r;
      m1_r  <= (64'(ua4_r) * 64'(ua4_r)) >>> FRAC_BITS;
      m2_r  <= (64'(ua4_r) * 64'(t2_r)) >>> FRAC_BITS;
      m3_r  <= (64'(xa4_r) * 64'(t4_r)) >>> FRAC_BITS;
    end
  end

  // Stage 6: quadratic coefficients
  logic signed [31:0] a6_r, h6_r, c6_r;

  always_ff @(posedge clk) begin
    if (f_en) begin
      a6_r <= sat32(70'(uu5_r) - 70'(m1_r));
      h6_r <= sat32(70'(ux5_r) - 70'(m2_r));
      c6_r <= sat32(70'(xx5_r) - 70'(m3_r));
    end
  end

  // Stage 7: discriminant products
  logic signed [31:0] a7_r, h7_r;
  logic signed [63:0] hh_r, ac_r;

  always_ff @(posedge clk) begin
    if (f_en) begin
      a7_r <= a6_r;
      h7_r <= h6_r;
      hh_r <= 64'(h6_r) * 64'(h6_r);
      ac_r <= 64'(a6_r) * 64'(c6_r);
    end
  end

  // Stage 8: quarter discriminant and flags
  logic signed [64:0] q_w;
  mid_item_t          m8_r;

  assign q_w = 65'(hh_r) - 65'(ac_r);

  always_ff @(posedge clk) begin
    if (f_en) begin
      m8_r.hit   <= !q_w[64];
      m8_r.degen <= (a7_r == '0);
      m8_r.h     <= h7_r;
      m8_r.a     <= a7_r;
      m8_r.q     <= q_w[64] ? 64'd0 : q_w[63:0];
    end
  end

  assign mid_item = m8_r;

endmodule

@@ sv/rpi_back.sv @@
`include "ray_paraboloid_intersect_core_macros.svh"

module rpi_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpi_pkg::mid_item_t mid_item,
  input  logic               mid_empty,
  output logic               mid_pop,
  output rpi_pkg::out_item_t out_item,
  output logic               out_empty,
  input  logic               out_pop
);
  import rpi_pkg::*;

  localparam int SQ_STEPS = 32;
  localparam int NB       = 33 + FRAC_BITS;

  logic b_en;
  logic out_vld_r;

  // Whole back pipeline moves when the output register frees up
  assign b_en      = !out_vld_r || out_pop;
  assign mid_pop   = b_en && !mid_empty;
  assign out_empty = !out_vld_r;

  // Square root stages, one root bit each
  logic               sq_vld_r  [SQ_STEPS+1];
  logic [63:0]        sq_rem_r  [SQ_STEPS+1];
  logic [31:0]        sq_root_r [SQ_STEPS+1];
  logic signed [31:0] sq_h_r    [SQ_STEPS+1];
  logic signed [31:0] sq_a_r    [SQ_STEPS+1];
  logic               sq_live_r [SQ_STEPS+1];
  logic               sq_hit_r  [SQ_STEPS+1];
  logic               sq_dg_r   [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (b_en) begin
      sq_vld_r[0] <= !mid_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      sq_rem_r[0]  <= mid_item.q;
      sq_root_r[0] <= '0;
      sq_h_r[0]    <= mid_item.h;
      sq_a_r[0]    <= mid_item.a;
      sq_live_r[0] <= mid_item.hit && !mid_item.degen;
      sq_hit_r[0]  <= mid_item.hit;
      sq_dg_r[0]   <= mid_item.degen;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    localparam int B = SQ_STEPS - 1 - i;
    logic [63:0] trial;
    logic        take;

    assign trial = ({32'd0, sq_root_r[i]} << (B + 1)) | (64'd1 << (2 * B));
    assign take  = sq_rem_r[i] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i+1] <= 1'b0;
      end else if (b_en) begin
        sq_vld_r[i+1] <= sq_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (b_en) begin
        sq_rem_r[i+1]  <= take ? sq_rem_r[i] - trial : sq_rem_r[i];
        sq_root_r[i+1] <= take ? (sq_root_r[i] | (32'd1 << B)) : sq_root_r[i];
        sq_h_r[i+1]    <= sq_h_r[i];
        sq_a_r[i+1]    <= sq_a_r[i];
        sq_live_r[i+1] <= sq_live_r[i];
        sq_hit_r[i+1]  <= sq_hit_r[i];
        sq_dg_r[i+1]   <= sq_dg_r[i];
      end
    end
  end

  // Numerators and divisor in sign-magnitude form
  logic signed [33:0] n_near_w, n_far_w;
  logic [32:0]        mag_near_w, mag_far_w;
  logic [31:0]        mag_a_w;

  assign n_near_w   = -34'(sq_h_r[SQ_STEPS]) - 34'(sq_root_r[SQ_STEPS]);
  assign n_far_w    = -34'(sq_h_r[SQ_STEPS]) + 34'(sq_root_r[SQ_STEPS]);
  assign mag_near_w = n_near_w[33] ? 33'(-n_near_w) : n_near_w[32:0];
  assign mag_far_w  = n_far_w[33] ? 33'(-n_far_w) : n_far_w[32:0];
  assign mag_a_w    = sq_a_r[SQ_STEPS][31] ? 32'(-sq_a_r[SQ_STEPS])
                                           : sq_a_r[SQ_STEPS][31:0];

  // Division stages, one quotient bit each for both roots
  logic          dv_vld_r   [NB+1];
  logic [31:0]   dv_d_r     [NB+1];
  logic [31:0]   dv_rn_r    [NB+1];
  logic [31:0]   dv_rf_r    [NB+1];
  logic [NB-1:0] dv_nn_r    [NB+1];
  logic [NB-1:0] dv_nf_r    [NB+1];
  logic          dv_sn_r    [NB+1];
  logic          dv_sf_r    [NB+1];
  logic          dv_live_r  [NB+1];
  logic          dv_hit_r   [NB+1];
  logic          dv_dg_r    [NB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (b_en) begin
      dv_vld_r[0] <= sq_vld_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      dv_d_r[0]    <= mag_a_w;
      dv_rn_r[0]   <= '0;
      dv_rf_r[0]   <= '0;
      dv_nn_r[0]   <= NB'(mag_near_w) << FRAC_BITS;
      dv_nf_r[0]   <= NB'(mag_far_w) << FRAC_BITS;
      dv_sn_r[0]   <= n_near_w[33] ^ sq_a_r[SQ_STEPS][31];
      dv_sf_r[0]   <= n_far_w[33] ^ sq_a_r[SQ_STEPS][31];
      dv_live_r[0] <= sq_live_r[SQ_STEPS];
      dv_hit_r[0]  <= sq_hit_r[SQ_STEPS];
      dv_dg_r[0]   <= sq_dg_r[SQ_STEPS];
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_dv
    logic [32:0] shn, shf;
    logic        gen, gef;

    assign shn = {dv_rn_r[j], dv_nn_r[j][NB-1]};
    assign shf = {dv_rf_r[j], dv_nf_r[j][NB-1]};
    assign gen = shn >= {1'b0, dv_d_r[j]};
    assign gef = shf >= {1'b0, dv_d_r[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (b_en) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (b_en) begin
        dv_rn_r[j+1]   <= gen ? 32'(shn - {1'b0, dv_d_r[j]}) : shn[31:0];
        dv_rf_r[j+1]   <= gef ? 32'(shf - {1'b0, dv_d_r[j]}) : shf[31:0];
        dv_nn_r[j+1]   <= {dv_nn_r[j][NB-2:0], gen};
        dv_nf_r[j+1]   <= {dv_nf_r[j][NB-2:0], gef};
        dv_d_r[j+1]    <= dv_d_r[j];
        dv_sn_r[j+1]   <= dv_sn_r[j];
        dv_sf_r[j+1]   <= dv_sf_r[j];
        dv_live_r[j+1] <= dv_live_r[j];
        dv_hit_r[j+1]  <= dv_hit_r[j];
        dv_dg_r[j+1]   <= dv_dg_r[j];
      end
    end
  end

  // Saturate the signed quotient to 32 bits
  function automatic logic signed [31:0] sat_quot(input logic [NB-1:0] qm, input logic neg);
    logic [NB-1:0]      lim_neg;
    logic [NB-1:0]      lim_pos;
    logic signed [31:0] r;
    lim_neg = {{(NB-32){1'b0}}, 32'h8000_0000};
    lim_pos = {{(NB-32){1'b0}}, 32'h7fff_ffff};
    if (neg) begin
      r = (qm > lim_neg) ? 32'sh8000_0000 : (~qm[31:0]) + 32'd1;
    end else begin
      r = (qm > lim_pos) ? 32'sh7fff_ffff : qm[31:0];
    end
    return r;
  endfunction

  // Output register
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_en) begin
      out_vld_r <= dv_vld_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      out_r.hit        <= dv_hit_r[NB];
      out_r.degenerate <= dv_dg_r[NB];
      out_r.root_near  <= dv_live_r[NB] ? sat_quot(dv_nn_r[NB], dv_sn_r[NB]) : '0;
      out_r.root_far   <= dv_live_r[NB] ? sat_quot(dv_nf_r[NB], dv_sf_r[NB]) : '0;
    end
  end

  assign out_item = out_r;

  `RPI_ASSERT_NOW(a_miss_zero, out_vld_r && !out_r.hit, out_r.root_near == '0 && out_r.root_far == '0, "miss with nonzero roots")
  `RPI_ASSERT_NOW(a_degen_zero, out_vld_r && out_r.degenerate, out_r.root_near == '0 && out_r.root_far == '0, "degenerate with nonzero roots")
  `RPI_ASSERT_NEXT(a_hold_out, out_vld_r && !out_pop, out_vld_r && $stable(out_r), "result dropped under stall")

endmodule

@@ sv/ray_paraboloid_intersect_core.sv @@
// Channel  Handshake            Payload
// in       push / full          in_item  (in_item_t, ray origin and direction)
// out      pop / empty          out_item (out_item_t, hit, degenerate, roots)
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One ray per cycle sustained while nothing stalls; each ray passes the front
// stages, the coefficient queue, the root and divide stages and the output register.
// The latency is set by the one-bit-per-stage root and divide pipelines.
// rst_n is synchronous; it clears valid bits and loads the register reset values.
// The front stalls only when the coefficient queue is full; the back stalls
// whole while a result sits in the output register and pop is low.
module ray_paraboloid_intersect_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rpi_pkg::in_item_t  in_item,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output rpi_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rpi_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  mid_item_t q_wr, q_rd;

  assign cfg_ready = 1'b1;

  rpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (push),
    .in_item   (in_item),
    .in_full   (full),
    .mid_push  (q_push),
    .mid_item  (q_wr),
    .mid_full  (q_full)
  );

  rpi_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd),
    .empty   (q_empty)
  );

  rpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_item  (q_rd),
    .mid_empty (q_empty),
    .mid_pop   (q_pop),
    .out_item  (out_item),
    .out_empty (empty),
    .out_pop   (pop)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import rpi_pkg::*;

  localparam int FRAC = 16;
  localparam int PHASES = 6;
  localparam int RAYS_PER_PHASE = 200;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, cfg_ready;
  in_item_t in_item = '0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow of the paraboloid registers, sign-extended
  longint shape_reg[7];

  in_item_t ray_queue[$];
  out_item_t hit_queue[$];

  int errors = 0;
  int rays_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int degens_seen = 0;
  int cfg_writes = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int quiet_cycles = 0;

  ray_paraboloid_intersect_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .in_item(in_item), .full(full),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed-point product, rounded toward minus infinity
  function automatic longint fmul(longint x, longint y);
    bit neg;
    longint unsigned mx, my, p;
    neg = (x < 0) != (y < 0);
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    p = mx * my;
    if (neg) return -longint'((p + ((64'd1 << FRAC) - 1)) >> FRAC);
    return longint'(p >> FRAC);
  endfunction

  function automatic longint dot3(longint p0, longint p1, longint p2,
                                  longint q0, longint q1, longint q2);
    return clamp32(fmul(p0, q0) + fmul(p1, q1) + fmul(p2, q2));
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint fdiv(longint n, longint d);
    return clamp32((n * (64'sd1 <<< FRAC)) / d);
  endfunction

  // Expected intersection of one ray with the current paraboloid
  function automatic out_item_t trace_ray(in_item_t r);
    longint x0, x1, x2, d0, d1, d2, k, uu, ux, xx, ua, xa, a, h, c, q, s;
    longint ax, ay, az;
    out_item_t res;
    x0 = longint'(r.origin_x) - shape_reg[REG_VERTEX_X];
    x1 = longint'(r.origin_y) - shape_reg[REG_VERTEX_Y];
    x2 = longint'(r.origin_z) - shape_reg[REG_VERTEX_Z];
    d0 = longint'(r.dir_x);
    d1 = longint'(r.dir_y);
    d2 = longint'(r.dir_z);
    ax = shape_reg[REG_AXIS_X];
    ay = shape_reg[REG_AXIS_Y];
    az = shape_reg[REG_AXIS_Z];
    k = shape_reg[REG_FOCAL_K];
    uu = dot3(d0, d1, d2, d0, d1, d2);
    ux = dot3(d0, d1, d2, x0, x1, x2);
    xx = dot3(x0, x1, x2, x0, x1, x2);
    ua = dot3(d0, d1, d2, ax, ay, az);
    xa = dot3(x0, x1, x2, ax, ay, az);
    a = clamp32(uu - fmul(ua, ua));
    h = clamp32(ux - fmul(ua, clamp32(xa + 2 * k)));
    c = clamp32(xx - fmul(xa, clamp32(xa + 4 * k)));
    q = h * h - a * c;
    res = '0;
    res.hit = (q >= 0);
    res.degenerate = (a == 0);
    if (res.hit && !res.degenerate) begin
      s = floor_sqrt(q);
      res.root_near = 32'(fdiv(-h - s, a));
      res.root_far = 32'(fdiv(-h + s, a));
    end
    return res;
  endfunction

  function automatic logic [31:0] small_q(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic in_item_t rand_ray();
    in_item_t r;
    logic signed [31:0] t;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      // Rays near the origin, mostly well inside range
      r.origin_x = small_q(1 << 20);
      r.origin_y = small_q(1 << 20);
      r.origin_z = small_q(1 << 20);
      r.dir_x = small_q(1 << 17);
      r.dir_y = small_q(1 << 17);
      r.dir_z = small_q(1 << 17);
    end else if (pick < 8) begin
      // Direction along the axis makes a vanish
      t = small_q(1 << 17);
      r.origin_x = small_q(1 << 20);
      r.origin_y = small_q(1 << 20);
      r.origin_z = small_q(1 << 20);
      r.dir_x = 32'(fmul(t, shape_reg[REG_AXIS_X]));
      r.dir_y = 32'(fmul(t, shape_reg[REG_AXIS_Y]));
      r.dir_z = 32'(fmul(t, shape_reg[REG_AXIS_Z]));
    end else begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end
    return r;
  endfunction

  function automatic in_item_t make_ray(longint ox, longint oy, longint oz,
                                        longint dx, longint dy, longint dz);
    in_item_t r;
    r.origin_x = 32'(ox);
    r.origin_y = 32'(oy);
    r.origin_z = 32'(oz);
    r.dir_x = 32'(dx);
    r.dir_y = 32'(dy);
    r.dir_z = 32'(dz);
    return r;
  endfunction

  // Sender: offer queued rays, predict on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        hit_queue.push_back(trace_ray(in_item));
        rays_sent++;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          push <= 1'b0;
        end else if (ray_queue.size() > 0) begin
          in_item <= ray_queue.pop_front();
          push <= 1'b1;
          send_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    int gap;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: result with nothing pending: got %p", $time, out_item);
          errors++;
        end else begin
          want = hit_queue.pop_front();
          if (out_item.hit !== want.hit || out_item.degenerate !== want.degenerate ||
              out_item.root_near !== want.root_near ||
              out_item.root_far !== want.root_far) begin
            $display("%0t: mismatch: expected %p, actual %p", $time, want, out_item);
            errors++;
          end
        end
        results_seen++;
        hits_seen += out_item.hit;
        degens_seen += out_item.degenerate;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
        recv_gap <= gap;
        if (results_seen == 100 && !hold_done) begin
          hold_left <= HOLD_CYCLES;
          hold_done <= 1'b1;
          pop <= 1'b0;
        end else begin
          // Keep popping back to back when no wait was drawn
          pop <= (gap == 0);
        end
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx inside {[REG_AXIS_X:REG_AXIS_Z]}) begin
      shape_reg[idx] = longint'($signed(value[17:0]));
    end else begin
      shape_reg[idx] = longint'($signed(value));
    end
    cfg_writes++;
  endtask

  task automatic set_shape(longint vx, longint vy, longint vz,
                           longint ax, longint ay, longint az, longint k);
    write_reg(REG_VERTEX_X, 32'(vx));
    write_reg(REG_VERTEX_Y, 32'(vy));
    write_reg(REG_VERTEX_Z, 32'(vz));
    write_reg(REG_AXIS_X, 32'(ax));
    write_reg(REG_AXIS_Y, 32'(ay));
    write_reg(REG_AXIS_Z, 32'(az));
    write_reg(REG_FOCAL_K, 32'(k));
  endtask

  initial begin
    shape_reg = '{0, 0, 0, 0, 65536, 0, 65536};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rays against the reset paraboloid
    ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0));
    ray_queue.push_back(make_ray(0, 5 << 16, 0, 0, 1 << 16, 0));
    ray_queue.push_back(make_ray(0, 5 << 16, 0, 1 << 16, 0, 0));
    ray_queue.push_back(make_ray(-3 << 16, 1 << 16, 0, 1 << 16, 0, 0));
    ray_queue.push_back(make_ray(0, -4 << 16, 0, 1 << 16, 0, 0));
    ray_queue.push_back(make_ray(0, 0, 2 << 16, 0, 0, -1 << 16));
    ray_queue.push_back(make_ray(1 << 16, 3 << 16, 1 << 16, -1 << 16, -2 << 16, 0));
    ray_queue.push_back(make_ray(0, 0, 0, 1, 0, 1));
    ray_queue.push_back(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    ray_queue.push_back(make_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                                 -64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
    ray_queue.push_back(make_ray(32'h7fffffff, -64'sd2147483648, 32'h7fffffff,
                                 -64'sd2147483648, 32'h7fffffff, -64'sd2147483648));
    ray_queue.push_back(make_ray(0, 1 << 16, 0, 0, -64'sd2147483648, 0));
    ray_queue.push_back(make_ray(-1, -1, -1, -1, -1, -1));

    for (int ph = 0; ph < PHASES; ph++) begin
      // Reprogram the paraboloid only while the block is drained
      while (ray_queue.size() > 0 || hit_queue.size() > 0 || push) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      case (ph)
        1: set_shape(small_q(1 << 18), small_q(1 << 18), small_q(1 << 18),
                     0, 0, 65536, small_q(1 << 18));
        2: set_shape(0, 0, 0, 65536, 0, 0, -2 << 16);
        3: set_shape(32'h7fffffff, -64'sd2147483648, 32'h7fffffff,
                     -65536, 65536, -65536, 32'h7fffffff);
        4: set_shape(-64'sd2147483648, 32'h7fffffff, 0,
                     -131072, 131071, 0, -64'sd2147483648);
        5: set_shape(small_q(1 << 18), small_q(1 << 18), small_q(1 << 18),
                     small_q(1 << 16), small_q(1 << 16), small_q(1 << 16), $urandom);
        default: ;
      endcase
      for (int i = 0; i < RAYS_PER_PHASE; i++) ray_queue.push_back(rand_ray());
    end

    while (ray_queue.size() > 0 || hit_queue.size() > 0 || push) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Traced %0d rays over %0d paraboloid settings (%0d register writes).",
             rays_sent, PHASES, cfg_writes);
    $display("Results: %0d, hits %0d, degenerate %0d, mismatches %0d.",
             results_seen, hits_seen, degens_seen, errors);
    if (errors == 0 && hit_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
